// ===== design/rpd_pkg.sv =====
// Shared types, constants and helper functions for the RK4 projectile drag step core.
package rpd_pkg;

    localparam int DRAG_W   = 24;
    localparam int GRAV_W   = 31;
    localparam int CFG_W    = 31;
    localparam int MUL_W    = 36;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ROOT_W   = 33;
    localparam int DIV_W    = 40;

    localparam logic [GRAV_W-1:0] GRAVITY_RST = 31'd642908;

    localparam logic REG_DRAG = 1'b0;
    localparam logic REG_GRAV = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] init_pos_x;
        logic signed [31:0] init_pos_y;
        logic signed [31:0] init_pos_z;
        logic signed [31:0] init_vel_x;
        logic signed [31:0] init_vel_y;
        logic signed [31:0] init_vel_z;
        logic [16:0]        step_time;
    } rpd_in_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               saturated;
    } rpd_out_t;

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

    function automatic logic f_ovf(input logic signed [49:0] v);
        logic o;
        o = (v > 50'sd2147483647) || (v < -50'sd2147483648);
        return o;
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/rpd_mul.sv =====
// Shared signed multiplier with a registered product.
module rpd_mul (
    input  logic                            clk,
    input  logic signed [rpd_pkg::MUL_W-1:0]  a,
    input  logic signed [rpd_pkg::MUL_W-1:0]  b,
    output logic signed [rpd_pkg::PROD_W-1:0] prod
);
    import rpd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== design/rpd_sqrt.sv =====
// Iterative integer square root, rounded to nearest, two radicand bits per cycle.
module rpd_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [63:0]                 radicand,
    output logic                        done,
    output logic [rpd_pkg::ROOT_W-1:0]  root
);
    import rpd_pkg::*;

    logic [63:0]       r_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       bit_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [63:0]       trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (bit_reg == 64'd0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= 64'd0;
            rem_reg <= radicand;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (bit_reg != 64'd0)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    r_reg   <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                root_reg <= (rem_reg > r_reg) ? ROOT_W'(r_reg + 64'd1) : ROOT_W'(r_reg);
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== design/rpd_div3.sv =====
// Radix-16 digit-serial divider by three for an unsigned operand.
module rpd_div3 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpd_pkg::DIV_W-1:0]  dividend,
    output logic                       done,
    output logic [rpd_pkg::DIV_W-1:0]  quotient
);
    import rpd_pkg::*;

    localparam int DIGITS = DIV_W / 4;

    logic [DIV_W-1:0] shr_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [1:0]       rem_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       val;
    logic [11:0]      scaled;
    logic [3:0]       qd;
    logic [5:0]       back;

    assign val    = {rem_reg, shr_reg[DIV_W-1 -: 4]};
    assign scaled = 12'(val) * 12'd43;
    assign qd     = scaled[10:7];
    assign back   = val - 6'(qd) * 6'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 4'(DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shr_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            shr_reg <= shr_reg << 4;
            quo_reg <= {quo_reg[DIV_W-5:0], qd};
            rem_reg <= back[1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/rk4_projectile_drag_step_core.sv =====
// Load item: taken into the state and passed on via the done state. Step item: four
// derivative evaluations, each with a square root and a chain of multiplies on one
// shared multiplier, and six radix-16 divisions by three in the final update.
// One item is in work at a time; a finished result waits in an output register.
// Reset is asynchronous and active low; it clears the state, the flags and sets the
// registers drag_coef to 0 and gravity to 9.81.
module rk4_projectile_drag_step_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  rpd_pkg::rpd_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output rpd_pkg::rpd_out_t            out_data,
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [rpd_pkg::CFG_W-1:0]    cfg_wdata
);
    import rpd_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ_MUL  = 4'd1;
    localparam logic [3:0] S_SQ_ACC  = 4'd2;
    localparam logic [3:0] S_RT_GO   = 4'd3;
    localparam logic [3:0] S_RT_WAIT = 4'd4;
    localparam logic [3:0] S_DR_MUL  = 4'd5;
    localparam logic [3:0] S_DR_P1   = 4'd6;
    localparam logic [3:0] S_DR_HI   = 4'd7;
    localparam logic [3:0] S_DR_LO   = 4'd8;
    localparam logic [3:0] S_DR_FIN  = 4'd9;
    localparam logic [3:0] S_ST_MUL  = 4'd10;
    localparam logic [3:0] S_ST_ADD  = 4'd11;
    localparam logic [3:0] S_FN_MUL  = 4'd12;
    localparam logic [3:0] S_FN_DIV  = 4'd13;
    localparam logic [3:0] S_FN_WAIT = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    localparam logic signed [53:0] DIV_BIAS = 54'sd206158430208;
    localparam logic signed [49:0] DIV_UNBIAS = 50'sd68719476736;

    logic [3:0]         state_reg;
    logic [2:0]         idx_reg;
    logic [1:0]         stage_reg;
    logic [16:0]        dt_reg;
    logic               sat_reg;
    logic [DRAG_W-1:0]  drag_reg;
    logic [GRAV_W-1:0]  grav_reg;
    logic signed [31:0] cur_reg [6];
    logic signed [31:0] t_reg [6];
    logic signed [31:0] k_reg [6];
    logic signed [34:0] acc_reg [6];
    logic [63:0]        sum_reg;
    logic [ROOT_W-1:0]  speed_reg;
    logic [46:0]        p1_reg;
    logic [46:0]        hp_reg;
    logic               out_valid_reg;
    rpd_out_t           out_data_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     rt_done;
    logic [ROOT_W-1:0]        rt_root;
    logic                     dv_start;
    logic [DIV_W-1:0]         dv_in;
    logic                     dv_done;
    logic [DIV_W-1:0]         dv_quo;

    logic signed [31:0] tv;
    logic [31:0]        vmag;
    logic signed [31:0] kr;
    logic signed [34:0] ar;
    logic signed [31:0] cr;
    logic [24:0]        lo_rnd;
    logic [47:0]        dmag;
    logic signed [49:0] dacc;
    logic signed [49:0] ps;
    logic signed [49:0] qstep;
    logic signed [49:0] stsum;
    logic signed [34:0] kw;
    logic signed [53:0] pf;
    logic signed [53:0] yb;
    logic signed [49:0] qfin;
    logic signed [49:0] fnsum;
    logic               out_free;

    assign tv       = t_reg[idx_reg + 3'd3];
    assign vmag     = f_mag(tv);
    assign kr       = k_reg[idx_reg];
    assign ar       = acc_reg[idx_reg];
    assign cr       = cur_reg[idx_reg];
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = {4'd0, vmag};
                mul_b = {4'd0, vmag};
            end
            S_DR_MUL:
            begin
                mul_a = {4'd0, vmag};
                mul_b = {3'd0, speed_reg};
            end
            S_DR_HI:
            begin
                mul_a = {13'd0, p1_reg[46:24]};
                mul_b = {12'd0, drag_reg};
            end
            S_DR_LO:
            begin
                mul_a = {12'd0, p1_reg[23:0]};
                mul_b = {12'd0, drag_reg};
            end
            S_ST_MUL:
            begin
                mul_a = {{4{kr[31]}}, kr};
                mul_b = {19'd0, dt_reg};
            end
            S_FN_MUL:
            begin
                mul_a = {ar[34], ar};
                mul_b = {19'd0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        lo_rnd = 25'((prod[47:0] + 48'h800000) >> 24);
        dmag   = hp_reg + 48'(lo_rnd);
        dacc   = tv[31] ? $signed({2'b00, dmag}) : -$signed({2'b00, dmag});
        if (idx_reg == 3'd1)
        begin
            dacc = dacc - $signed({19'd0, grav_reg});
        end
        ps = prod[49:0];
        if (stage_reg == 2'd2)
        begin
            qstep = (ps + 50'sd32768) >>> 16;
        end
        else
        begin
            qstep = (ps + 50'sd65536) >>> 17;
        end
        stsum = {{18{cr[31]}}, cr} + qstep;
        if (stage_reg == 2'd0 || stage_reg == 2'd3)
        begin
            kw = {{3{kr[31]}}, kr};
        end
        else
        begin
            kw = {{2{kr[31]}}, kr, 1'b0};
        end
        pf    = prod[53:0];
        yb    = ((pf + 54'sd196608) >>> 17) + DIV_BIAS;
        dv_in = yb[DIV_W-1:0];
        qfin  = $signed({10'd0, dv_quo}) - DIV_UNBIAS;
        fnsum = {{18{cr[31]}}, cr} + qfin;
    end

    assign dv_start = (state_reg == S_FN_DIV);

    rpd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rpd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_RT_GO),
        .radicand (sum_reg),
        .done     (rt_done),
        .root     (rt_root)
    );

    rpd_div3 u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_in),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg <= '0;
            grav_reg <= GRAVITY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DRAG: drag_reg <= cfg_wdata[DRAG_W-1:0];
                REG_GRAV: grav_reg <= cfg_wdata[GRAV_W-1:0];
                default:  drag_reg <= drag_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            stage_reg     <= 2'd0;
            sat_reg       <= 1'b0;
            dt_reg        <= '0;
            sum_reg       <= '0;
            speed_reg     <= '0;
            p1_reg        <= '0;
            hp_reg        <= '0;
            for (int i = 0; i < 6; i++)
            begin
                cur_reg[i] <= '0;
                t_reg[i]   <= '0;
                k_reg[i]   <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sat_reg   <= 1'b0;
                        idx_reg   <= 3'd0;
                        stage_reg <= 2'd0;
                        sum_reg   <= '0;
                        dt_reg    <= in_data.step_time;
                        if (in_data.mode == MODE_LOAD)
                        begin
                            cur_reg[0] <= in_data.init_pos_x;
                            cur_reg[1] <= in_data.init_pos_y;
                            cur_reg[2] <= in_data.init_pos_z;
                            cur_reg[3] <= in_data.init_vel_x;
                            cur_reg[4] <= in_data.init_vel_y;
                            cur_reg[5] <= in_data.init_vel_z;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            for (int i = 0; i < 6; i++)
                            begin
                                t_reg[i]   <= cur_reg[i];
                                acc_reg[i] <= '0;
                            end
                            state_reg <= S_SQ_MUL;
                        end
                    end
                end
                S_SQ_MUL:
                begin
                    state_reg <= S_SQ_ACC;
                end
                S_SQ_ACC:
                begin
                    sum_reg <= sum_reg + prod[63:0];
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg   <= 3'd0;
                        state_reg <= S_RT_GO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_RT_GO:
                begin
                    state_reg <= S_RT_WAIT;
                end
                S_RT_WAIT:
                begin
                    if (rt_done)
                    begin
                        speed_reg <= rt_root;
                        state_reg <= S_DR_MUL;
                    end
                end
                S_DR_MUL:
                begin
                    state_reg <= S_DR_P1;
                end
                S_DR_P1:
                begin
                    p1_reg    <= 47'((prod[63:0] + 64'h8000) >> 16);
                    state_reg <= S_DR_HI;
                end
                S_DR_HI:
                begin
                    state_reg <= S_DR_LO;
                end
                S_DR_LO:
                begin
                    hp_reg    <= prod[46:0];
                    state_reg <= S_DR_FIN;
                end
                S_DR_FIN:
                begin
                    k_reg[idx_reg]        <= tv;
                    k_reg[idx_reg + 3'd3] <= f_clamp(dacc);
                    sat_reg               <= sat_reg | f_ovf(dacc);
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg   <= 3'd0;
                        state_reg <= S_ST_MUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= S_DR_MUL;
                    end
                end
                S_ST_MUL:
                begin
                    state_reg <= S_ST_ADD;
                end
                S_ST_ADD:
                begin
                    acc_reg[idx_reg] <= ar + kw;
                    if (stage_reg != 2'd3)
                    begin
                        t_reg[idx_reg] <= f_clamp(stsum);
                        sat_reg        <= sat_reg | f_ovf(stsum);
                    end
                    if (idx_reg == 3'd5)
                    begin
                        idx_reg <= 3'd0;
                        if (stage_reg == 2'd3)
                        begin
                            state_reg <= S_FN_MUL;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 2'd1;
                            sum_reg   <= '0;
                            state_reg <= S_SQ_MUL;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= S_ST_MUL;
                    end
                end
                S_FN_MUL:
                begin
                    state_reg <= S_FN_DIV;
                end
                S_FN_DIV:
                begin
                    state_reg <= S_FN_WAIT;
                end
                S_FN_WAIT:
                begin
                    if (dv_done)
                    begin
                        cur_reg[idx_reg] <= f_clamp(fnsum);
                        sat_reg          <= sat_reg | f_ovf(fnsum);
                        if (idx_reg == 3'd5)
                        begin
                            idx_reg   <= 3'd0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_FN_MUL;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.out_pos_x <= cur_reg[0];
            out_data_reg.out_pos_y <= cur_reg[1];
            out_data_reg.out_pos_z <= cur_reg[2];
            out_data_reg.out_vel_x <= cur_reg[3];
            out_data_reg.out_vel_y <= cur_reg[4];
            out_data_reg.out_vel_z <= cur_reg[5];
            out_data_reg.saturated <= sat_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/rpd_chk.sv =====
// Port-level checker for the RK4 projectile drag step core, with its bind.
module rpd_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input rpd_pkg::rpd_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input rpd_pkg::rpd_out_t out_data
);
    import rpd_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Core took an item without going busy.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result item changed or dropped.");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("Result item appeared while the core stayed busy.");

    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.mode == MODE_LOAD && !out_valid
        |-> ##2 out_valid && out_data.out_pos_x == $past(in_data.init_pos_x, 2)
            && !out_data.saturated)
        else $error("Load item did not return its state two cycles later.");

endmodule

bind rk4_projectile_drag_step_core rpd_chk u_rpd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the RK4 projectile drag step core with a built-in predictor.
module testbench;
    import rpd_pkg::*;

    localparam int N_RANDOM = 1850;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        rpd_in_t  item;
        logic     check_fixed;
        rpd_out_t fixed;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rpd_in_t in_data;
    logic out_valid;
    logic out_stall;
    rpd_out_t out_data;
    logic cfg_we;
    logic cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    rk4_projectile_drag_step_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    logic [DRAG_W-1:0] model_drag;
    logic [GRAV_W-1:0] model_grav;
    longint model_state [6];
    rpd_out_t expected_q [$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit out_idle_on;
    bit in_idle_on;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_sat(input longint v, inout bit sat);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic longint round_div(input longint x, input longint d);
        longint n;
        longint dd;
        n = 2 * x + d;
        dd = 2 * d;
        if (n >= 0)
        begin
            return n / dd;
        end
        return -((-n + dd - 1) / dd);
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r = 0;
        b = 64'd1 << 62;
        rem = n;
        while (b > rem)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (rem > r)
        begin
            r = r + 1;
        end
        return r;
    endfunction

    task automatic rates_of(input longint st [6], output longint k [6], inout bit sat);
        longint unsigned mag [3];
        longint unsigned sum;
        longint unsigned speed;
        longint unsigned p1;
        longint unsigned d;
        longint acc;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (st[3+i] < 0) ? longint'(-st[3+i]) : longint'(st[3+i]);
            sum = sum + mag[i] * mag[i];
            k[i] = st[3+i];
        end
        speed = root_nearest(sum);
        for (int i = 0; i < 3; i++)
        begin
            p1 = (mag[i] * speed + 64'h8000) >> 16;
            d = (p1 >> 24) * model_drag
                + (((p1 & 64'hFFFFFF) * model_drag + 64'h800000) >> 24);
            acc = (st[3+i] < 0) ? longint'(d) : -longint'(d);
            if (i == 1)
            begin
                acc = acc - longint'(model_grav);
            end
            k[3+i] = clamp_sat(acc, sat);
        end
    endtask

    task automatic advance_state(input rpd_in_t it, output rpd_out_t res);
        bit sat;
        longint dt;
        longint k1 [6];
        longint k2 [6];
        longint k3 [6];
        longint k4 [6];
        longint t [6];
        sat = 1'b0;
        if (it.mode == MODE_LOAD)
        begin
            model_state[0] = it.init_pos_x;
            model_state[1] = it.init_pos_y;
            model_state[2] = it.init_pos_z;
            model_state[3] = it.init_vel_x;
            model_state[4] = it.init_vel_y;
            model_state[5] = it.init_vel_z;
        end
        else
        begin
            dt = it.step_time;
            rates_of(model_state, k1, sat);
            for (int i = 0; i < 6; i++)
                t[i] = clamp_sat(model_state[i] + round_div(k1[i] * dt, 131072), sat);
            rates_of(t, k2, sat);
            for (int i = 0; i < 6; i++)
                t[i] = clamp_sat(model_state[i] + round_div(k2[i] * dt, 131072), sat);
            rates_of(t, k3, sat);
            for (int i = 0; i < 6; i++)
                t[i] = clamp_sat(model_state[i] + round_div(k3[i] * dt, 65536), sat);
            rates_of(t, k4, sat);
            for (int i = 0; i < 6; i++)
                model_state[i] = clamp_sat(model_state[i] + round_div(
                    (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) * dt, 6 * 65536), sat);
        end
        res.out_pos_x = model_state[0][31:0];
        res.out_pos_y = model_state[1][31:0];
        res.out_pos_z = model_state[2][31:0];
        res.out_vel_x = model_state[3][31:0];
        res.out_vel_y = model_state[4][31:0];
        res.out_vel_z = model_state[5][31:0];
        res.saturated = sat;
    endtask

    task automatic note_mismatch(input string what, input longint e, input longint a);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("Mismatch on %s: expected %0d, got %0d", what, e, a);
        end
    endtask

    always @(posedge clk)
    begin
        rpd_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result item %p", out_data);
                end
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.out_pos_x !== out_data.out_pos_x)
                    note_mismatch("out_pos_x", e.out_pos_x, out_data.out_pos_x);
                if (e.out_pos_y !== out_data.out_pos_y)
                    note_mismatch("out_pos_y", e.out_pos_y, out_data.out_pos_y);
                if (e.out_pos_z !== out_data.out_pos_z)
                    note_mismatch("out_pos_z", e.out_pos_z, out_data.out_pos_z);
                if (e.out_vel_x !== out_data.out_vel_x)
                    note_mismatch("out_vel_x", e.out_vel_x, out_data.out_vel_x);
                if (e.out_vel_y !== out_data.out_vel_y)
                    note_mismatch("out_vel_y", e.out_vel_y, out_data.out_vel_y);
                if (e.out_vel_z !== out_data.out_vel_z)
                    note_mismatch("out_vel_z", e.out_vel_z, out_data.out_vel_z);
                if (e.saturated !== out_data.saturated)
                    note_mismatch("saturated", e.saturated, out_data.saturated);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= out_idle_on && ($urandom_range(99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            timed_out = 1'b1;
            $display("rk4_projectile_drag_step_core verification failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed(32'($urandom_range(1 << 22))) - (1 << 21);
        endcase
    endfunction

    function automatic rpd_in_t rand_item();
        rpd_in_t it;
        it.mode = ($urandom_range(99) < 80) ? MODE_STEP : MODE_LOAD;
        it.init_pos_x = rand_word();
        it.init_pos_y = rand_word();
        it.init_pos_z = rand_word();
        it.init_vel_x = rand_word();
        it.init_vel_y = rand_word();
        it.init_vel_z = rand_word();
        case ($urandom_range(4))
            0: it.step_time = $urandom_range(131071);
            1: it.step_time = 17'd65536;
            default: it.step_time = $urandom_range(6554);
        endcase
        return it;
    endfunction

    task automatic send_item(input rpd_in_t it, input bit use_fixed, input rpd_out_t fixed);
        rpd_out_t res;
        if (in_idle_on)
        begin
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_state(it, res);
        expected_q.push_back(use_fixed ? fixed : res);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        if (idx == REG_DRAG)
            model_drag = v[DRAG_W-1:0];
        else
            model_grav = v[GRAV_W-1:0];
    endtask

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        rpd_out_t none;
        rpd_in_t fresh;
        logic [CFG_W-1:0] drag_set [5];
        logic [CFG_W-1:0] grav_set [5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_DRAG;
        cfg_wdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        out_idle_on = 1'b1;
        in_idle_on = 1'b1;
        model_drag = '0;
        model_grav = GRAVITY_RST;
        for (int i = 0; i < 6; i++)
            model_state[i] = 0;
        none = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r.check_fixed = 1'b1;
        r.item = '0;
        r.item.mode = MODE_STEP;
        r.fixed = '0;
        rows.push_back(r);
        r.item.mode = MODE_LOAD;
        r.item.init_pos_x = 32'sh7FFFFFFF;
        r.item.init_pos_y = 32'sh80000000;
        r.item.init_pos_z = 32'sh7FFFFFFF;
        r.item.init_vel_x = 32'sh80000000;
        r.item.init_vel_y = 32'sh7FFFFFFF;
        r.item.init_vel_z = 32'sh80000000;
        r.item.step_time = 17'h1FFFF;
        r.fixed = {32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                   32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0};
        rows.push_back(r);
        r.check_fixed = 1'b0;
        r.item.mode = MODE_STEP;
        r.item.step_time = 17'd0;
        rows.push_back(r);
        r.item.step_time = 17'h1FFFF;
        rows.push_back(r);
        r.item = '0;
        r.item.init_pos_y = 32'sh00640000;
        r.item.init_vel_x = 32'sh000A0000;
        r.item.init_vel_y = 32'sh00140000;
        rows.push_back(r);
        r.item.mode = MODE_STEP;
        for (int i = 0; i < 4; i++)
        begin
            r.item.step_time = 17'd6554 << i;
            rows.push_back(r);
        end
        r.item.step_time = 17'd65536;
        rows.push_back(r);
        r.item.step_time = 17'd131071;
        rows.push_back(r);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].check_fixed, rows[i].fixed);
        drain_and_settle();

        drag_set = '{31'hFFFFFF, 31'd0, 31'd16777, 31'd1677721, 31'd1};
        grav_set = '{31'h7FFFFFFF, 31'd0, 31'd642908, 31'd65536, 31'd1};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_DRAG, drag_set[ph]);
            write_reg(REG_GRAV, grav_set[ph]);
            cfg_we <= 1'b0;
            out_idle_on = (ph != 2);
            in_idle_on = (ph != 2);
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                if (n % 8 == 0)
                begin
                    r.item = rand_item();
                end
                else
                begin
                    fresh = rand_item();
                    r.item.step_time = fresh.step_time;
                end
                r.item.mode = (n % 8 == 0) ? MODE_LOAD : MODE_STEP;
                if ($urandom_range(9) == 0)
                    r.item = rand_item();
                send_item(r.item, 1'b0, none);
            end
            drain_and_settle();
        end

        if (mismatches == 0 && expected_q.size() == 0 && !timed_out)
        begin
            $display("rk4_projectile_drag_step_core verification clean");
        end
        else
        begin
            $display("rk4_projectile_drag_step_core verification failed");
        end
        $finish;
    end
endmodule
